@@ rtl/core/assert_macros.svh @@
// Assertion helpers shared by the core. Each use stands on a line of its own.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AAT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aat: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define AAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aat: next-cycle check failed");

`endif

@@ rtl/core/aat_pkg.sv @@
package aat_pkg;

    localparam int AXES           = 3;
    localparam int COORD_WIDTH    = 32;
    localparam int COEF_WIDTH     = 20;
    localparam int FRAC_BITS      = 16;
    localparam int SHIFT_WIDTH    = 32;
    localparam int ROW_WIDTH      = AXES * COEF_WIDTH;
    localparam int FULL_WIDTH     = COORD_WIDTH + COEF_WIDTH;
    localparam int PROD_WIDTH     = FULL_WIDTH - FRAC_BITS;
    // Three products and the translation are summed without loss.
    localparam int SUM_WIDTH      = ((PROD_WIDTH > SHIFT_WIDTH) ? PROD_WIDTH : SHIFT_WIDTH) + 2;
    localparam int CFG_ADDR_WIDTH = 3;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int TDATA_WIDTH    = ((2 * AXES * COORD_WIDTH + 7) / 8) * 8;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [COEF_WIDTH-1:0]  coef_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [SUM_WIDTH-1:0]   sum_t;
    typedef logic signed [SHIFT_WIDTH-1:0] shift_t;
    typedef logic signed [FULL_WIDTH-1:0]  full_t;
    typedef logic [ROW_WIDTH-1:0]          row_t;

    localparam coef_t  COEF_ONE  = coef_t'(1 << FRAC_BITS);
    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_ADDR_WIDTH-1:0] {
        CFG_ROW_X    = 3'd0,
        CFG_ROW_Y    = 3'd1,
        CFG_ROW_Z    = 3'd2,
        CFG_SHIFT_XY = 3'd3,
        CFG_SHIFT_Z  = 3'd4
    } cfg_reg_t;

    // A zero coefficient counts as non-positive and takes the swapped corners.
    function automatic logic coef_positive(coef_t c);
        return !c[COEF_WIDTH-1] && (c != '0);
    endfunction

endpackage

@@ rtl/core/aat_opsel.sv @@
module aat_opsel (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  aat_pkg::coord_t box_min [aat_pkg::AXES],
    input  aat_pkg::coord_t box_max [aat_pkg::AXES],
    input  aat_pkg::coef_t  coef    [aat_pkg::AXES][aat_pkg::AXES],
    output logic           out_valid,
    input  logic           out_ready,
    output aat_pkg::coord_t lo_op   [aat_pkg::AXES][aat_pkg::AXES],
    output aat_pkg::coord_t hi_op   [aat_pkg::AXES][aat_pkg::AXES]
);

    logic            valid_reg;
    aat_pkg::coord_t lo_op_reg  [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::coord_t hi_op_reg  [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::coord_t lo_op_next [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::coord_t hi_op_next [aat_pkg::AXES][aat_pkg::AXES];

    assign in_ready = !valid_reg || out_ready;

    // Index order is [input axis][output axis].
    always_comb begin
        for (int i = 0; i < aat_pkg::AXES; i++) begin
            for (int j = 0; j < aat_pkg::AXES; j++) begin
                if (aat_pkg::coef_positive(coef[i][j])) begin
                    lo_op_next[i][j] = box_min[i];
                    hi_op_next[i][j] = box_max[i];
                end else begin
                    lo_op_next[i][j] = box_max[i];
                    hi_op_next[i][j] = box_min[i];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            lo_op_reg <= lo_op_next;
            hi_op_reg <= hi_op_next;
        end
    end

    assign out_valid = valid_reg;
    assign lo_op     = lo_op_reg;
    assign hi_op     = hi_op_reg;

endmodule

@@ rtl/core/aat_mul.sv @@
`include "assert_macros.svh"

module aat_mul (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  aat_pkg::coord_t lo_op   [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::coord_t hi_op   [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::coef_t  coef    [aat_pkg::AXES][aat_pkg::AXES],
    output logic           out_valid,
    input  logic           out_ready,
    output aat_pkg::prod_t  prod_lo [aat_pkg::AXES][aat_pkg::AXES],
    output aat_pkg::prod_t  prod_hi [aat_pkg::AXES][aat_pkg::AXES]
);

    logic           valid_reg;
    aat_pkg::full_t full_lo      [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::full_t full_hi      [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::prod_t prod_lo_reg  [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::prod_t prod_hi_reg  [aat_pkg::AXES][aat_pkg::AXES];

    assign in_ready = !valid_reg || out_ready;

    // Dropping the fraction bits of the exact product floors towards minus infinity.
    always_comb begin
        for (int i = 0; i < aat_pkg::AXES; i++) begin
            for (int j = 0; j < aat_pkg::AXES; j++) begin
                full_lo[i][j] = aat_pkg::full_t'(lo_op[i][j]) * aat_pkg::full_t'(coef[i][j]);
                full_hi[i][j] = aat_pkg::full_t'(hi_op[i][j]) * aat_pkg::full_t'(coef[i][j]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            for (int i = 0; i < aat_pkg::AXES; i++) begin
                for (int j = 0; j < aat_pkg::AXES; j++) begin
                    prod_lo_reg[i][j] <= full_lo[i][j][aat_pkg::FULL_WIDTH-1:aat_pkg::FRAC_BITS];
                    prod_hi_reg[i][j] <= full_hi[i][j][aat_pkg::FULL_WIDTH-1:aat_pkg::FRAC_BITS];
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign prod_lo   = prod_lo_reg;
    assign prod_hi   = prod_hi_reg;

    // A held product must not be overwritten while the next stage is full.
    `AAT_ASSERT_NEXT(a_mul_hold, aclk, aresetn, valid_reg && !out_ready, valid_reg && $stable(prod_lo_reg[0][0]) && $stable(prod_hi_reg[2][2]))

endmodule

@@ rtl/core/aat_sum.sv @@
`include "assert_macros.svh"

module aat_sum (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  aat_pkg::prod_t  prod_lo [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::prod_t  prod_hi [aat_pkg::AXES][aat_pkg::AXES],
    input  aat_pkg::shift_t shift   [aat_pkg::AXES],
    output logic            out_valid,
    input  logic            out_ready,
    output aat_pkg::coord_t out_min [aat_pkg::AXES],
    output aat_pkg::coord_t out_max [aat_pkg::AXES],
    output logic            saturated
);

    localparam int PEXT = aat_pkg::SUM_WIDTH - aat_pkg::PROD_WIDTH;
    localparam int SEXT = aat_pkg::SUM_WIDTH - aat_pkg::SHIFT_WIDTH;
    localparam int HEAD = aat_pkg::SUM_WIDTH - aat_pkg::COORD_WIDTH + 1;

    logic            valid_a_reg;
    logic            valid_b_reg;
    logic            ready_b;
    aat_pkg::sum_t   pa_lo_reg [aat_pkg::AXES];
    aat_pkg::sum_t   pb_lo_reg [aat_pkg::AXES];
    aat_pkg::sum_t   pa_hi_reg [aat_pkg::AXES];
    aat_pkg::sum_t   pb_hi_reg [aat_pkg::AXES];
    aat_pkg::sum_t   pa_lo_next [aat_pkg::AXES];
    aat_pkg::sum_t   pb_lo_next [aat_pkg::AXES];
    aat_pkg::sum_t   pa_hi_next [aat_pkg::AXES];
    aat_pkg::sum_t   pb_hi_next [aat_pkg::AXES];
    aat_pkg::sum_t   sum_lo [aat_pkg::AXES];
    aat_pkg::sum_t   sum_hi [aat_pkg::AXES];
    logic [aat_pkg::AXES-1:0] ovf_lo;
    logic [aat_pkg::AXES-1:0] ovf_hi;
    aat_pkg::coord_t out_min_next [aat_pkg::AXES];
    aat_pkg::coord_t out_max_next [aat_pkg::AXES];
    aat_pkg::coord_t out_min_reg  [aat_pkg::AXES];
    aat_pkg::coord_t out_max_reg  [aat_pkg::AXES];
    logic            sat_reg;
    logic            at_bound;

    assign ready_b  = !valid_b_reg || out_ready;
    assign in_ready = !valid_a_reg || ready_b;

    // First adder stage: two partial sums per output corner.
    always_comb begin
        for (int j = 0; j < aat_pkg::AXES; j++) begin
            pa_lo_next[j] = {{PEXT{prod_lo[0][j][aat_pkg::PROD_WIDTH-1]}}, prod_lo[0][j]}
                          + {{PEXT{prod_lo[1][j][aat_pkg::PROD_WIDTH-1]}}, prod_lo[1][j]};
            pb_lo_next[j] = {{PEXT{prod_lo[2][j][aat_pkg::PROD_WIDTH-1]}}, prod_lo[2][j]}
                          + {{SEXT{shift[j][aat_pkg::SHIFT_WIDTH-1]}}, shift[j]};
            pa_hi_next[j] = {{PEXT{prod_hi[0][j][aat_pkg::PROD_WIDTH-1]}}, prod_hi[0][j]}
                          + {{PEXT{prod_hi[1][j][aat_pkg::PROD_WIDTH-1]}}, prod_hi[1][j]};
            pb_hi_next[j] = {{PEXT{prod_hi[2][j][aat_pkg::PROD_WIDTH-1]}}, prod_hi[2][j]}
                          + {{SEXT{shift[j][aat_pkg::SHIFT_WIDTH-1]}}, shift[j]};
        end
    end

    // Second stage: final sum and clamp. The sum fits the coordinate when all of
    // its bits from the coordinate's sign bit upwards agree.
    always_comb begin
        for (int j = 0; j < aat_pkg::AXES; j++) begin
            sum_lo[j] = pa_lo_reg[j] + pb_lo_reg[j];
            sum_hi[j] = pa_hi_reg[j] + pb_hi_reg[j];
            ovf_lo[j] = (|sum_lo[j][aat_pkg::SUM_WIDTH-1 -: HEAD])
                     && !(&sum_lo[j][aat_pkg::SUM_WIDTH-1 -: HEAD]);
            ovf_hi[j] = (|sum_hi[j][aat_pkg::SUM_WIDTH-1 -: HEAD])
                     && !(&sum_hi[j][aat_pkg::SUM_WIDTH-1 -: HEAD]);
            if (ovf_lo[j]) begin
                out_min_next[j] = sum_lo[j][aat_pkg::SUM_WIDTH-1] ? aat_pkg::COORD_MIN
                                                                  : aat_pkg::COORD_MAX;
            end else begin
                out_min_next[j] = sum_lo[j][aat_pkg::COORD_WIDTH-1:0];
            end
            if (ovf_hi[j]) begin
                out_max_next[j] = sum_hi[j][aat_pkg::SUM_WIDTH-1] ? aat_pkg::COORD_MIN
                                                                  : aat_pkg::COORD_MAX;
            end else begin
                out_max_next[j] = sum_hi[j][aat_pkg::COORD_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                valid_a_reg <= in_valid;
            end
            if (ready_b) begin
                valid_b_reg <= valid_a_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            pa_lo_reg <= pa_lo_next;
            pb_lo_reg <= pb_lo_next;
            pa_hi_reg <= pa_hi_next;
            pb_hi_reg <= pb_hi_next;
        end
        if (valid_a_reg && ready_b) begin
            out_min_reg <= out_min_next;
            out_max_reg <= out_max_next;
            sat_reg     <= |{ovf_lo, ovf_hi};
        end
    end

    always_comb begin
        at_bound = 1'b0;
        for (int j = 0; j < aat_pkg::AXES; j++) begin
            if (out_min_reg[j] == aat_pkg::COORD_MAX || out_min_reg[j] == aat_pkg::COORD_MIN
                || out_max_reg[j] == aat_pkg::COORD_MAX
                || out_max_reg[j] == aat_pkg::COORD_MIN) begin
                at_bound = 1'b1;
            end
        end
    end

    assign out_valid = valid_b_reg;
    assign out_min   = out_min_reg;
    assign out_max   = out_max_reg;
    assign saturated = sat_reg;

    // A clamped result must show at least one coordinate pinned to a range limit.
    `AAT_ASSERT_SAME(a_sum_sat_bound, aclk, aresetn, valid_b_reg && sat_reg, at_bound)
    // The partial-sum stage only moves on into an empty or draining output stage.
    `AAT_ASSERT_NEXT(a_sum_advance, aclk, aresetn, valid_a_reg && ready_b, valid_b_reg)

endmodule

@@ rtl/core/aabb_affine_transform_core.sv @@
// Box transform core: each transaction on the slave side carries one axis-aligned
// box (signed Q16.16 min and max corners) and yields one transaction on the master
// side with the box that encloses it after the affine transform held in the
// configuration registers, saturated to Q16.16 with tuser raised when any corner
// was clamped. The core takes one box per clock cycle while s_tready is high; its
// stages: operand selection, one bank of eighteen 32 x 20 multipliers, and two
// adder stages, the second of which also clamps and serves as the output register.
// Each stage holds its data while the stage after it is full, so back-pressure only
// reaches s_tready once all four stages hold a box. Configuration writes take
// effect at once and must only be made while no box is in flight.
`include "assert_macros.svh"

module aabb_affine_transform_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [aat_pkg::CFG_ADDR_WIDTH-1:0]  cfg_addr,
    input  logic [aat_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    // Box input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
    input  logic [aat_pkg::TDATA_WIDTH-1:0]     s_tdata,
    // Transformed box output.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [aat_pkg::TDATA_WIDTH-1:0]     m_tdata,
    // saturated
    output logic                                m_tuser
);

    aat_pkg::row_t    row_coefs_reg [aat_pkg::AXES];
    logic [2*aat_pkg::SHIFT_WIDTH-1:0] shift_xy_reg;
    aat_pkg::shift_t  shift_z_reg;

    aat_pkg::coef_t   coef    [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::shift_t  shift   [aat_pkg::AXES];
    aat_pkg::coord_t  box_min [aat_pkg::AXES];
    aat_pkg::coord_t  box_max [aat_pkg::AXES];
    aat_pkg::coord_t  lo_op   [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::coord_t  hi_op   [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::prod_t   prod_lo [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::prod_t   prod_hi [aat_pkg::AXES][aat_pkg::AXES];
    aat_pkg::coord_t  out_min [aat_pkg::AXES];
    aat_pkg::coord_t  out_max [aat_pkg::AXES];
    logic             sel_valid;
    logic             sel_ready;
    logic             mul_valid;
    logic             mul_ready;

    // Register i of the input row is reset to the identity coefficient at output axis i.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < aat_pkg::AXES; i++) begin
                row_coefs_reg[i] <= aat_pkg::row_t'(aat_pkg::COEF_ONE)
                                    << (i * aat_pkg::COEF_WIDTH);
            end
            shift_xy_reg <= '0;
            shift_z_reg  <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                aat_pkg::CFG_ROW_X:    row_coefs_reg[0] <= cfg_wdata[aat_pkg::ROW_WIDTH-1:0];
                aat_pkg::CFG_ROW_Y:    row_coefs_reg[1] <= cfg_wdata[aat_pkg::ROW_WIDTH-1:0];
                aat_pkg::CFG_ROW_Z:    row_coefs_reg[2] <= cfg_wdata[aat_pkg::ROW_WIDTH-1:0];
                aat_pkg::CFG_SHIFT_XY: shift_xy_reg <= cfg_wdata[2*aat_pkg::SHIFT_WIDTH-1:0];
                aat_pkg::CFG_SHIFT_Z:  shift_z_reg  <= cfg_wdata[aat_pkg::SHIFT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int i = 0; i < aat_pkg::AXES; i++) begin
            for (int j = 0; j < aat_pkg::AXES; j++) begin
                coef[i][j] = row_coefs_reg[i][j*aat_pkg::COEF_WIDTH +: aat_pkg::COEF_WIDTH];
            end
            box_min[i] = s_tdata[i*aat_pkg::COORD_WIDTH +: aat_pkg::COORD_WIDTH];
            box_max[i] = s_tdata[(i+aat_pkg::AXES)*aat_pkg::COORD_WIDTH +: aat_pkg::COORD_WIDTH];
        end
        shift[0] = shift_xy_reg[aat_pkg::SHIFT_WIDTH-1:0];
        shift[1] = shift_xy_reg[2*aat_pkg::SHIFT_WIDTH-1:aat_pkg::SHIFT_WIDTH];
        shift[2] = shift_z_reg;
    end

    aat_opsel u_opsel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .box_min   (box_min),
        .box_max   (box_max),
        .coef      (coef),
        .out_valid (sel_valid),
        .out_ready (sel_ready),
        .lo_op     (lo_op),
        .hi_op     (hi_op)
    );

    aat_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (sel_valid),
        .in_ready  (sel_ready),
        .lo_op     (lo_op),
        .hi_op     (hi_op),
        .coef      (coef),
        .out_valid (mul_valid),
        .out_ready (mul_ready),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi)
    );

    aat_sum u_sum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (mul_valid),
        .in_ready  (mul_ready),
        .prod_lo   (prod_lo),
        .prod_hi   (prod_hi),
        .shift     (shift),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_min   (out_min),
        .out_max   (out_max),
        .saturated (m_tuser)
    );

    always_comb begin
        m_tdata = '0;
        for (int j = 0; j < aat_pkg::AXES; j++) begin
            m_tdata[j*aat_pkg::COORD_WIDTH +: aat_pkg::COORD_WIDTH] = out_min[j];
            m_tdata[(j+aat_pkg::AXES)*aat_pkg::COORD_WIDTH +: aat_pkg::COORD_WIDTH] = out_max[j];
        end
    end

    // The input side can only be held off when every stage, the output included, is full.
    `AAT_ASSERT_SAME(a_top_stall_full, aclk, aresetn, !s_tready, m_tvalid && !m_tready && sel_valid && mul_valid)

endmodule
